@@ rtl/hoac_pkg.sv @@
package hoac_pkg;

  // Fixed field widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned FrameW  = 11;

  // Shortest frame that the block runs, and the frame length after reset.
  localparam int unsigned MinPoints = 4;
  localparam logic [FrameW-1:0] FrameReset = 11'd1024;

  typedef logic signed [SampleW-1:0] sample_t;

  // One incoming complex sample.
  typedef struct packed {
    sample_t in_re;
    sample_t in_im;
  } in_item_t;

  // One overlap-added result.
  typedef struct packed {
    sample_t out_re;
    sample_t out_im;
    logic    last_of_half;
  } out_item_t;

  // A stored tail sample from the second half of the previous frame.
  typedef struct packed {
    sample_t im;
    sample_t re;
  } tail_word_t;

  // A halved first-half sample waiting for its tail partner.
  typedef struct packed {
    sample_t re;
    sample_t im;
    logic    last;
  } half_item_t;

  // Halve a sample, rounding toward zero.
  function automatic sample_t halve(input sample_t x);
    logic [SampleW-1:0] t;
    t = x + {{(SampleW-1){1'b0}}, x[SampleW-1]};
    return {t[SampleW-1], t[SampleW-1:1]};
  endfunction

endpackage

@@ rtl/half_overlap_add_combiner.sv @@
// 50 percent overlap-add of complex frames. Samples arrive in index order,
// frame after frame, each one halved (rounding toward zero) on entry. A
// sample from the second half of a frame is parked in the tail store and
// produces no result; a sample at index i of the first half is added to the
// parked sample half+i of the previous frame and produces one result, with
// last_of_half set on the final result of each half frame. The effective
// frame length is the register clamped to 4..MAX_POINTS; an odd length
// gives the extra sample to the second half. The block takes one item per
// clock cycle unless the input stalls; the item is held in the first of a
// row of two identical register cells while the tail store read register
// fetches its partner, and the sum is registered in the second cell. The
// cells hand items forward and can hold them under back pressure. After reset
// the tail store is zeroed over its MAX_POINTS/2 entries, one entry per cycle,
// during which the input stalls; frame length writes are taken at any time.
// The frame length should be written only while no item is in flight.
module half_overlap_add_combiner
  import hoac_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [FrameW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_o
);

  localparam int unsigned TailDepth = MAX_POINTS / 2;
  localparam int unsigned TailAw    = $clog2(TailDepth);
  localparam int unsigned IdxW      = $clog2(MAX_POINTS);
  localparam int unsigned LenNatW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned LenW      = (FrameW > LenNatW) ? FrameW : LenNatW;
  localparam int unsigned HalfW     = $bits(half_item_t);
  localparam int unsigned OutW      = $bits(out_item_t);

  // Configuration register and frame position.
  logic [FrameW-1:0] frame_points_q;
  logic [IdxW-1:0]   idx_q, idx_d;

  // Index and length arithmetic.
  logic [LenW-1:0]   fp_ext;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   half;
  logic [LenW-1:0]   cur;
  logic [LenW-1:0]   cur_inc;
  logic [LenW-1:0]   diff;
  logic [LenW-1:0]   slot_hi;
  logic              first_half;
  logic              last;

  // Handshake and memory hookup.
  logic              in_acc;
  logic              clr_busy;
  logic              rd_en;
  logic              wr_en;
  logic [TailAw-1:0] rd_addr;
  logic [TailAw-1:0] wr_addr;
  tail_word_t        wr_word;
  tail_word_t        rd_word;
  sample_t           h_re;
  sample_t           h_im;

  // Cell row.
  half_item_t        s1_in;
  half_item_t        s1_item;
  logic [HalfW-1:0]  s1_data;
  logic              s1_valid;
  logic              s1_stall;
  out_item_t         s2_in;
  logic [OutW-1:0]   s2_data;
  logic              s2_stall;

  // The register takes every write; there is nothing to wait for.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_points_q <= FrameReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_points_q <= cfg_data_i;
    end
  end

  // Effective length is the register clamped to the supported range.
  always_comb begin
    fp_ext = LenW'(frame_points_q);
    if (fp_ext < LenW'(MinPoints)) begin
      len = LenW'(MinPoints);
    end else if (fp_ext > LenW'(MAX_POINTS)) begin
      len = LenW'(MAX_POINTS);
    end else begin
      len = fp_ext;
    end
    half = len >> 1;
  end

  // A position left beyond a shortened frame starts a new frame. Second-half
  // slots can only reach the store depth itself for an odd maximum length,
  // which folds back to slot zero.
  always_comb begin
    cur = (LenW'(idx_q) >= len) ? '0 : LenW'(idx_q);
    first_half = (cur < half);
    last = (cur == (half - 1'b1));
    diff = cur - half;
    slot_hi = (diff >= LenW'(TailDepth)) ? (diff - LenW'(TailDepth)) : diff;
    cur_inc = cur + 1'b1;
    idx_d = (cur_inc >= len) ? '0 : IdxW'(cur_inc);
  end

  assign in_stall_o = clr_busy | s1_stall;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (in_acc) begin
      idx_q <= idx_d;
    end
  end

  assign h_re = halve(in_i.in_re);
  assign h_im = halve(in_i.in_im);

  // First-half items read their partner; second-half items are stored.
  assign rd_en      = in_acc & first_half;
  assign wr_en      = in_acc & ~first_half;
  assign rd_addr    = cur[TailAw-1:0];
  assign wr_addr    = slot_hi[TailAw-1:0];
  assign wr_word.re = h_re;
  assign wr_word.im = h_im;

  hoac_tail_mem #(
    .DEPTH (TailDepth),
    .AW    (TailAw)
  ) u_tail_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_word),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_word),
    .clr_busy_o (clr_busy)
  );

  assign s1_in.re   = h_re;
  assign s1_in.im   = h_im;
  assign s1_in.last = last;

  // First cell: the halved sample, while its partner comes out of the store.
  // The store read register holds until the next first-half item is taken,
  // and that only happens when this cell moves on.
  hoac_cell #(
    .W (HalfW)
  ) u_cell_read (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_en),
    .data_i  (s1_in),
    .stall_o (s1_stall),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .stall_i (s2_stall)
  );

  assign s1_item = half_item_t'(s1_data);

  // Both addends lie within half range, so the sum never wraps.
  assign s2_in.out_re       = s1_item.re + rd_word.re;
  assign s2_in.out_im       = s1_item.im + rd_word.im;
  assign s2_in.last_of_half = s1_item.last;

  // Second cell: the finished result, held while the output stalls.
  hoac_cell #(
    .W (OutW)
  ) u_cell_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s2_in),
    .stall_o (s2_stall),
    .valid_o (out_valid_o),
    .data_o  (s2_data),
    .stall_i (out_stall_i)
  );

  assign out_o = out_item_t'(s2_data);

`ifndef SYNTHESIS
  // No item may slip in while the tail store is being zeroed.
  a_stall_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("input not stalled during tail store clear");

  // A taken first-half item always lands in the read cell.
  a_first_half_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> s1_valid)
    else $error("first-half item lost before the add");

  // While the read cell holds under back pressure, its store data must not move.
  a_read_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_stall |=> $stable(rd_word))
    else $error("tail read data changed under a held item");
`endif

endmodule

@@ rtl/hoac_cell.sv @@
module hoac_cell #(
  parameter int unsigned W = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         stall_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         stall_i
);

  logic         valid_q;
  logic [W-1:0] data_q;

  // The cell only holds while it has an item that its neighbor refuses.
  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/hoac_tail_mem.sv @@
module hoac_tail_mem
  import hoac_pkg::*;
#(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  tail_word_t    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output tail_word_t    rd_data_o,
  output logic          clr_busy_o
);

  tail_word_t    mem [DEPTH];
  tail_word_t    rd_data_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // After reset every entry is zeroed, one per cycle.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule
